/* hdl/lgc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, register indexes and the threshold builder for the linear-to-gamma encoder.
// Depends on nothing; every other file of the block uses it.

package lgc_pkg;

  localparam int LIN_W      = 32;
  localparam int CODE_W     = 8;
  localparam int IDX_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int LANES      = 3;

  // Widest threshold the builder hands back (fraction bits up to 24, plus one).
  localparam int THR_MAX_W  = 25;
  // Working width of the exact comparison used while building the table.
  localparam int BIG_W      = 1536;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic MODE_BT709 = 1'b0;
  localparam logic MODE_SRGB  = 1'b1;

  typedef logic signed [LIN_W-1:0] lin_t;
  typedef logic [CODE_W-1:0]       code_t;

  typedef struct packed {
    lin_t lin_red;
    lin_t lin_green;
    lin_t lin_blue;
  } lin_pix_t;

  typedef struct packed {
    code_t code_red;
    code_t code_green;
    code_t code_blue;
  } codes_t;

  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Smallest input (with frac fraction bits) that reaches code k in the given mode.
  // Evaluated only at elaboration; the comparisons are the transfer curves with the
  // rounding point at k - 0.5, cleared of fractions and roots so they are exact.
  function automatic logic [THR_MAX_W-1:0] threshold(input int mode, input int k,
                                                     input int frac);
    logic [BIG_W-1:0] dpow;
    logic [BIG_W-1:0] rk;
    logic [BIG_W-1:0] xp;
    logic [BIG_W-1:0] lhs;
    logic [63:0]      nbase;
    logic [63:0]      dbase;
    logic [63:0]      one;
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [63:0]      mid;
    int               e;
    int               p;
    bit               reach;
    one = 64'd1 << frac;
    if (k == 0) begin
      return '0;
    end
    e     = (mode == 1) ? 12 : 20;
    p     = (mode == 1) ? 5 : 9;
    dbase = (mode == 1) ? 64'd107610 : 64'd560641381672815420;
    nbase = (mode == 1) ? (64'd400 * 64'(k) + 64'd5410)
                        : (64'(2 * k - 1) * 64'd1000000000000000 + 64'd50641381672815420);
    dpow  = BIG_W'(1);
    rk    = BIG_W'(1);
    for (int i = 0; i < e; i++) begin
      dpow = dpow * BIG_W'(dbase);
      rk   = rk * BIG_W'(nbase);
    end
    rk = rk << (p * frac);
    lo = '0;
    hi = one;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (mode == 1 && k <= 10) begin
        reach = (64'd32946 * mid) >= (64'(2 * k - 1) * 64'd5 * one);
      end else if (mode == 0 && k <= 21) begin
        reach = (64'd2295 * mid) >= (64'(2 * k - 1) * one);
      end else begin
        xp = BIG_W'(1);
        for (int i = 0; i < p; i++) begin
          xp = xp * BIG_W'(mid);
        end
        lhs   = xp * dpow;
        reach = (lhs >= rk);
      end
      if (reach) begin
        hi = mid;
      end else begin
        lo = mid + 64'd1;
      end
    end
    return THR_MAX_W'(lo);
  endfunction

endpackage

/* hdl/lgc_if.sv */
`timescale 1ns / 1ps
// Handshake channels of the encoder: linear pixel in, encoded result out, register writes.
// Depends on lgc_pkg for the payload widths.

interface lgc_in_if;
  logic          valid;
  logic          ready;
  lgc_pkg::lin_t lin_red;
  lgc_pkg::lin_t lin_green;
  lgc_pkg::lin_t lin_blue;

  modport source (output valid, output lin_red, output lin_green, output lin_blue,
                  input ready);
  modport sink   (input valid, input lin_red, input lin_green, input lin_blue,
                  output ready);
endinterface

interface lgc_out_if;
  logic                           valid;
  logic                           ready;
  lgc_pkg::code_t                 code_red;
  lgc_pkg::code_t                 code_green;
  lgc_pkg::code_t                 code_blue;
  logic [lgc_pkg::IDX_W-1:0]      dest_index;
  logic                           frame_end;

  modport source (output valid, output code_red, output code_green, output code_blue,
                  output dest_index, output frame_end, input ready);
  modport sink   (input valid, input code_red, input code_green, input code_blue,
                  input dest_index, input frame_end, output ready);
endinterface

interface lgc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lgc_pkg::CFG_IDX_W-1:0]  index;
  logic [lgc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/lgc_search.sv */
`timescale 1ns / 1ps
// Three-lane binary search over the per-mode threshold tables, one code bit per cycle.
// Depends on lgc_pkg for the pixel types and the threshold builder.

module lgc_search #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              mode_i,
  input  lgc_pkg::lin_pix_t pix_i,
  output logic              done_o,
  output lgc_pkg::codes_t   codes_o
);

  localparam int TW    = FRAC_BITS + 1;
  localparam int DEPTH = 256;

  logic [TW-1:0] rom0_w [DEPTH];
  logic [TW-1:0] rom1_w [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    localparam logic [TW-1:0] T0 = TW'(lgc_pkg::threshold(0, g, FRAC_BITS));
    localparam logic [TW-1:0] T1 = TW'(lgc_pkg::threshold(1, g, FRAC_BITS));
    assign rom0_w[g] = T0;
    assign rom1_w[g] = T1;
  end

  logic [lgc_pkg::CODE_W-1:0] bit_q;
  logic                       done_q;
  logic                       mode_q;
  logic [TW-1:0]              x_q    [lgc_pkg::LANES];
  lgc_pkg::code_t             code_q [lgc_pkg::LANES];
  lgc_pkg::code_t             code_d [lgc_pkg::LANES];
  lgc_pkg::lin_t              raw_w  [lgc_pkg::LANES];

  assign raw_w[0] = pix_i.lin_red;
  assign raw_w[1] = pix_i.lin_green;
  assign raw_w[2] = pix_i.lin_blue;

  // Each lane probes the candidate with the current bit set and keeps it if reached.
  for (genvar l = 0; l < lgc_pkg::LANES; l++) begin : g_lane
    lgc_pkg::code_t cand_w;
    logic [TW-1:0]  thr_w;
    assign cand_w    = code_q[l] | bit_q;
    assign thr_w     = mode_q ? rom1_w[cand_w] : rom0_w[cand_w];
    assign code_d[l] = (x_q[l] >= thr_w) ? cand_w : code_q[l];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      bit_q  <= {1'b1, {(lgc_pkg::CODE_W - 1){1'b0}}};
      done_q <= 1'b0;
    end else if (bit_q != '0) begin
      bit_q  <= bit_q >> 1;
      done_q <= bit_q[0];
    end
  end

  // Clamp to [0, 1] on the way in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= mode_i;
      for (int l = 0; l < lgc_pkg::LANES; l++) begin
        code_q[l] <= '0;
        if (raw_w[l][lgc_pkg::LIN_W-1]) begin
          x_q[l] <= '0;
        end else if (raw_w[l] > (lgc_pkg::lin_t'(1) <<< FRAC_BITS)) begin
          x_q[l] <= TW'(1) << FRAC_BITS;
        end else begin
          x_q[l] <= TW'(raw_w[l]);
        end
      end
    end else if (bit_q != '0) begin
      for (int l = 0; l < lgc_pkg::LANES; l++) begin
        code_q[l] <= code_d[l];
      end
    end
  end

  assign done_o             = done_q;
  assign codes_o.code_red   = code_q[0];
  assign codes_o.code_green = code_q[1];
  assign codes_o.code_blue  = code_q[2];

  a_bit_onehot0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(bit_q))
    else $error("search bit pointer is not one-hot");

  a_start_msb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> bit_q[lgc_pkg::CODE_W-1] && !done_q)
    else $error("search did not restart at the top bit");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> bit_q == '0)
    else $error("search flagged done while still stepping");

endmodule

/* hdl/lgc_index.sv */
`timescale 1ns / 1ps
// Frame position counters: flipped destination index, end-of-frame flag, size registers.
// Depends on lgc_pkg for the register write struct and index width.

module lgc_index #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lgc_pkg::cfg_wr_t           cfg_i,
  input  logic                       advance_i,
  output logic [lgc_pkg::IDX_W-1:0]  dest_index_o,
  output logic                       frame_end_o
);

  localparam int DATA_MAX = (1 << lgc_pkg::CFG_DATA_W) - 1;
  localparam int EW_MAX   = (MAX_WIDTH > DATA_MAX) ? DATA_MAX : MAX_WIDTH;
  localparam int EH_MAX   = (MAX_HEIGHT > DATA_MAX) ? DATA_MAX : MAX_HEIGHT;
  localparam int EW_W     = $clog2(EW_MAX + 1);
  localparam int EH_W     = $clog2(EH_MAX + 1);
  localparam int COL_W    = (EW_MAX > 1) ? $clog2(EW_MAX) : 1;
  localparam int ROW_W    = (EH_MAX > 1) ? $clog2(EH_MAX) : 1;
  localparam int EW_RST   = (1024 > EW_MAX) ? EW_MAX : 1024;
  localparam int EH_RST   = (1024 > EH_MAX) ? EH_MAX : 1024;
  localparam int IW       = lgc_pkg::IDX_W;
  localparam logic [IW-1:0] BASE_RST = IW'(EW_RST * (EH_RST - 1));

  function automatic logic [EW_W-1:0] clamp_w(input logic [lgc_pkg::CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return EW_W'(1);
    end
    if (v > lgc_pkg::CFG_DATA_W'(EW_MAX)) begin
      return EW_W'(EW_MAX);
    end
    return EW_W'(v);
  endfunction

  function automatic logic [EH_W-1:0] clamp_h(input logic [lgc_pkg::CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return EH_W'(1);
    end
    if (v > lgc_pkg::CFG_DATA_W'(EH_MAX)) begin
      return EH_W'(EH_MAX);
    end
    return EH_W'(v);
  endfunction

  logic [EW_W-1:0]      eff_w_q;
  logic [EH_W-1:0]      eff_h_q;
  logic [COL_W-1:0]     col_q;
  logic [ROW_W-1:0]     rows_q;
  logic [IW-1:0]        row_base_q;
  logic [IW-1:0]        prod_q;
  logic                 stale_q;
  logic [EW_W+EH_W-1:0] prod_full;
  logic [IW-1:0]        base_w;
  logic                 row_end;
  logic                 last;

  // Start-of-frame base, width times (height - 1), registered in the cycle after the size registers.
  assign prod_full = (EW_W + EH_W)'(eff_w_q) * (EW_W + EH_W)'(eff_h_q - EH_W'(1));
  assign base_w    = stale_q ? prod_q : row_base_q;
  assign row_end   = (EW_W'(col_q) + EW_W'(1)) >= eff_w_q;
  assign last      = row_end && (rows_q == '0);

  assign dest_index_o = base_w + IW'(col_q);
  assign frame_end_o  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q    <= EW_W'(EW_RST);
      eff_h_q    <= EH_W'(EH_RST);
      col_q      <= '0;
      rows_q     <= ROW_W'(EH_RST - 1);
      row_base_q <= BASE_RST;
      prod_q     <= BASE_RST;
      stale_q    <= 1'b1;
    end else begin
      prod_q <= IW'(prod_full);
      if (cfg_i.wr) begin
        unique case (cfg_i.idx)
          lgc_pkg::CFG_WIDTH: begin
            eff_w_q <= clamp_w(cfg_i.data);
            col_q   <= '0;
            rows_q  <= ROW_W'(eff_h_q - EH_W'(1));
            stale_q <= 1'b1;
          end
          lgc_pkg::CFG_HEIGHT: begin
            eff_h_q <= clamp_h(cfg_i.data);
            col_q   <= '0;
            rows_q  <= ROW_W'(clamp_h(cfg_i.data) - EH_W'(1));
            stale_q <= 1'b1;
          end
          default: begin
          end
        endcase
      end else if (advance_i) begin
        if (last) begin
          col_q   <= '0;
          rows_q  <= ROW_W'(eff_h_q - EH_W'(1));
          stale_q <= 1'b1;
        end else if (row_end) begin
          col_q      <= '0;
          rows_q     <= rows_q - ROW_W'(1);
          row_base_q <= base_w - IW'(eff_w_q);
          stale_q    <= 1'b0;
        end else begin
          col_q      <= col_q + COL_W'(1);
          row_base_q <= base_w;
          stale_q    <= 1'b0;
        end
      end
    end
  end

  a_col_in_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW_W'(col_q) < eff_w_q)
    else $error("column count ran past the row width");

  a_last_row_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && last |-> dest_index_o == IW'(col_q))
    else $error("last pixel of frame is not on destination row zero");

endmodule

/* hdl/linear_to_gamma_rgb8_encoder.sv */
`timescale 1ns / 1ps
// Each input transaction runs through 8 search steps and 1 load before its result is valid.
// The shared compare lanes serve one pixel at a time; the next is taken once the last is loaded.
// The next pixel is taken while the previous result still waits in the output register.
// Reset clears the handshake state, selects BT.709 and sets a 1024 by 1024 frame.
// Top level of the linear-to-gamma encoder; uses lgc_pkg, the lgc_*_if channels,
// lgc_search and lgc_index.

module linear_to_gamma_rgb8_encoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lgc_in_if.sink    pix_i,
  lgc_cfg_if.sink   cfg_i,
  lgc_out_if.source res_o
);

  // Two-state sequencer: idle and taking pixels, or busy with the search of one pixel.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic                       state_q;
  logic                       state_d;
  logic                       mode_q;
  logic                       in_acc;
  logic                       out_load;
  logic                       srch_done;
  logic                       out_vld_q;
  lgc_pkg::codes_t            codes_w;
  lgc_pkg::codes_t            codes_q;
  lgc_pkg::lin_pix_t          pix_w;
  lgc_pkg::cfg_wr_t           cfg_w;
  logic [lgc_pkg::IDX_W-1:0]  dest_w;
  logic [lgc_pkg::IDX_W-1:0]  dest_q;
  logic                       fend_w;
  logic                       fend_q;

  // Register writes are always taken unchecked; the host must write only while no pixel is in flight.
  assign cfg_i.ready = 1'b1;
  assign cfg_w.wr    = cfg_i.valid;
  assign cfg_w.idx   = cfg_i.index;
  assign cfg_w.data  = cfg_i.data;

  assign pix_i.ready = (state_q == ST_IDLE);
  assign in_acc      = pix_i.valid && pix_i.ready;

  assign pix_w.lin_red   = pix_i.lin_red;
  assign pix_w.lin_green = pix_i.lin_green;
  assign pix_w.lin_blue  = pix_i.lin_blue;

  // A finished search moves into the output register once that register is free,
  // or is being emptied in the same cycle. The frame counters advance at that moment.
  assign out_load = (state_q == ST_BUSY) && srch_done && (!out_vld_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      mode_q    <= lgc_pkg::MODE_BT709;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_w.wr && cfg_w.idx == lgc_pkg::CFG_MODE) begin
        mode_q <= cfg_w.data[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      codes_q <= codes_w;
      dest_q  <= dest_w;
      fend_q  <= fend_w;
    end
  end

  // The transfer mode is sampled when the pixel enters the search.
  lgc_search #(
    .FRAC_BITS (FRAC_BITS)
  ) u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .mode_i  (mode_q),
    .pix_i   (pix_w),
    .done_o  (srch_done),
    .codes_o (codes_w)
  );

  lgc_index #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_index (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_w),
    .advance_i    (out_load),
    .dest_index_o (dest_w),
    .frame_end_o  (fend_w)
  );

  assign res_o.valid      = out_vld_q;
  assign res_o.code_red   = codes_q.code_red;
  assign res_o.code_green = codes_q.code_green;
  assign res_o.code_blue  = codes_q.code_blue;
  assign res_o.dest_index = dest_q;
  assign res_o.frame_end  = fend_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_BUSY && !srch_done)
    else $error("pixel transaction did not start a search");

  a_load_after_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_vld_q && state_q == ST_IDLE)
    else $error("finished search did not reach the output register");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_o.ready |-> !out_load)
    else $error("output register overwritten while its result was stalled");

endmodule

/* tb/sv/linear_to_gamma_rgb8_encoder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for linear_to_gamma_rgb8_encoder: directed and random pixels over
// several frame and transfer settings, with random stalls on both channels.
// Depends on lgc_pkg, the lgc_in_if, lgc_out_if and lgc_cfg_if channels and the encoder RTL.

module linear_to_gamma_rgb8_encoder_tb;

  localparam int              MAX_DIM      = 4096;
  localparam int              FRAC         = 16;
  localparam int unsigned     FULL_SCALE   = 1 << FRAC;
  // Working width of the exact threshold comparison; the widest product is about 1330 bits.
  localparam int              WIDE         = 1536;
  localparam int              RANDOM_ITEMS = 1950;
  localparam int              CYCLE_LIMIT  = 1_000_000;
  localparam int              MAX_REPORTS  = 40;
  // BT.709 curve constants scaled by 10^15, so that the comparison stays in integers.
  localparam longint unsigned BT_A         = 64'd1099296826809442;
  localparam longint unsigned BT_B         = 64'd99296826809442;

  typedef struct packed {
    lgc_pkg::codes_t           codes;
    logic [lgc_pkg::IDX_W-1:0] dest;
    logic                      last;
  } encoded_pix_t;

  typedef struct packed {
    logic [lgc_pkg::CFG_IDX_W-1:0]  idx;
    logic [lgc_pkg::CFG_DATA_W-1:0] data;
  } reg_wr_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  lgc_in_if  pix ();
  lgc_cfg_if cfg ();
  lgc_out_if res ();

  linear_to_gamma_rgb8_encoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // code_floor[mode][k] is the smallest clamped input that gives a byte of at least k.
  logic [FRAC:0] code_floor [2][256];

  // Register copy and frame position of the predictor.
  logic                           cur_mode;
  logic [lgc_pkg::CFG_DATA_W-1:0] width_reg;
  logic [lgc_pkg::CFG_DATA_W-1:0] height_reg;
  int unsigned                    col_pos;
  int unsigned                    rows_left;
  logic [lgc_pkg::IDX_W-1:0]      row_base;

  lgc_pkg::lin_pix_t linear_q [$];   // pixels waiting to be offered to the encoder
  encoded_pix_t      encoded_q [$];  // predicted results, oldest first
  reg_wr_t           reg_writes [$]; // register writes of the next settings change

  lgc_pkg::lin_pix_t next_pix;
  lgc_pkg::lin_pix_t taken_pix;
  encoded_pix_t      want;
  int unsigned       src_gap;
  int unsigned       sink_stall;
  bit                src_calm;
  bit                sink_calm;
  int unsigned       mismatches;
  int unsigned       cycle_cnt;

  // Exact big-integer power by repeated squaring.
  function automatic logic [WIDE-1:0] wide_pow(longint unsigned base, int unsigned e);
    logic [WIDE-1:0] acc;
    logic [WIDE-1:0] sq;
    acc = WIDE'(1);
    sq  = WIDE'(base);
    while (e != 0) begin
      if (e[0]) begin
        acc = acc * sq;
      end
      e = e >> 1;
      if (e != 0) begin
        sq = sq * sq;
      end
    end
    return acc;
  endfunction

  // True when input x reaches code k. The linear toe of each curve is a plain product; the
  // power segment compares x^p * dpow with rhs, both cleared of roots and fractions.
  function automatic bit reaches_code(bit mode, int k, int unsigned x,
                                      logic [WIDE-1:0] dpow, logic [WIDE-1:0] rhs);
    longint unsigned lx;
    lx = x;
    if (mode == lgc_pkg::MODE_SRGB && k <= 10) begin
      return 64'd32946 * lx >= 64'(2 * k - 1) * 64'd5 * 64'(FULL_SCALE);
    end
    if (mode == lgc_pkg::MODE_BT709 && k <= 21) begin
      return 64'd2295 * lx >= 64'(2 * k - 1) * 64'(FULL_SCALE);
    end
    return wide_pow(lx, (mode == lgc_pkg::MODE_SRGB) ? 5 : 9) * dpow >= rhs;
  endfunction

  // Each floor starts from a floating-point guess of the inverse curve and is then moved by
  // single steps with the exact test, never below the floor of the code beneath it.
  function automatic void build_code_floors();
    logic [WIDE-1:0] dpow;
    logic [WIDE-1:0] rhs;
    longint unsigned nb;
    int unsigned     t;
    int unsigned     lo_bound;
    real             v;
    real             lin;
    for (int m = 0; m < 2; m++) begin
      dpow = wide_pow((m == 1) ? 64'd107610 : 64'd510 * BT_A, (m == 1) ? 12 : 20);
      code_floor[m][0] = '0;
      lo_bound = 0;
      for (int k = 1; k < 256; k++) begin
        nb  = (m == 1) ? 64'(400 * k + 5410)
                       : 64'(2 * k - 1) * 64'd1000000000000000 + 64'd510 * BT_B;
        rhs = wide_pow(nb, (m == 1) ? 12 : 20) << (((m == 1) ? 5 : 9) * FRAC);
        v   = (k - 0.5) / 255.0;
        if (m == 1) begin
          lin = (v <= 0.04045) ? v / 12.92 : ((v + 0.055) / 1.055) ** 2.4;
        end else begin
          lin = (v < 0.081) ? v / 4.5
                            : ((v + 0.099296826809442) / 1.099296826809442) ** (1.0 / 0.45);
        end
        t = $rtoi(lin * FULL_SCALE);
        if (t < lo_bound) begin
          t = lo_bound;
        end
        if (t > FULL_SCALE) begin
          t = FULL_SCALE;
        end
        while (t > lo_bound && reaches_code(m, k, t - 1, dpow, rhs)) begin
          t--;
        end
        while (t < FULL_SCALE && !reaches_code(m, k, t, dpow, rhs)) begin
          t++;
        end
        code_floor[m][k] = t;
        lo_bound = t;
      end
    end
  endfunction

  // Clamp to [0, full scale]; the byte is then the highest code whose floor is reached.
  function automatic lgc_pkg::code_t gamma_code(logic mode, lgc_pkg::lin_t v);
    int unsigned    x;
    lgc_pkg::code_t c;
    if (v[lgc_pkg::LIN_W-1]) begin
      x = 0;
    end else if (unsigned'(v) > FULL_SCALE) begin
      x = FULL_SCALE;
    end else begin
      x = unsigned'(v);
    end
    c = '0;
    for (int k = 1; k < 256; k++) begin
      if (x >= code_floor[mode][k]) begin
        c = lgc_pkg::code_t'(k);
      end
    end
    return c;
  endfunction

  // Zero counts as one and anything above the maximum saturates.
  function automatic int unsigned eff_dim(logic [lgc_pkg::CFG_DATA_W-1:0] raw);
    if (raw == 0) begin
      return 1;
    end
    return (raw > MAX_DIM) ? MAX_DIM : raw;
  endfunction

  function automatic void restart_frame();
    col_pos   = 0;
    rows_left = eff_dim(height_reg) - 1;
    row_base  = lgc_pkg::IDX_W'(eff_dim(width_reg) * rows_left);
  endfunction

  // Works out the result of one accepted pixel and steps the frame position. Rows are
  // written bottom up, so the base index falls by one row width at each row end.
  function automatic void gamma_encode_pixel(lgc_pkg::lin_pix_t p);
    encoded_pix_t e;
    int unsigned  w;
    bit           row_end;
    w = eff_dim(width_reg);
    e.codes.code_red   = gamma_code(cur_mode, p.lin_red);
    e.codes.code_green = gamma_code(cur_mode, p.lin_green);
    e.codes.code_blue  = gamma_code(cur_mode, p.lin_blue);
    e.dest  = lgc_pkg::IDX_W'(row_base + col_pos);
    row_end = (col_pos + 1 >= w);
    e.last  = row_end && rows_left == 0;
    encoded_q.push_back(e);
    if (e.last) begin
      restart_frame();
    end else if (row_end) begin
      col_pos   = 0;
      rows_left = rows_left - 1;
      row_base  = row_base - lgc_pkg::IDX_W'(w);
    end else begin
      col_pos++;
    end
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one; none at all in calm stretches.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Most levels fall in the useful range or on or next to a code boundary; the rest cover the
  // smallest levels, the clamping regions and every bit of the 32-bit field.
  function automatic lgc_pkg::lin_t random_level(logic mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return lgc_pkg::lin_t'($urandom_range(0, FULL_SCALE));
    end
    if (r < 62) begin
      return lgc_pkg::lin_t'(code_floor[mode][$urandom_range(1, 255)])
             + lgc_pkg::lin_t'($urandom_range(0, 2)) - 1;
    end
    if (r < 72) begin
      return lgc_pkg::lin_t'($urandom_range(0, 63));
    end
    if (r < 82) begin
      return lgc_pkg::lin_t'(FULL_SCALE - 8 + $urandom_range(0, 4000));
    end
    return lgc_pkg::lin_t'($urandom());
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Blocks until every queued pixel has been taken and every predicted result has arrived.
  // The check is made at the falling edge, once everything driven at the rising edge has
  // settled, and the task returns on the next rising edge.
  task automatic wait_drained();
    do @(negedge clk_i); while (linear_q.size() != 0 || pix.valid || encoded_q.size() != 0);
    @(posedge clk_i);
  endtask

  // Issues the queued register writes back to back. The valid stays high between writes,
  // and the predictor copy follows each write at the edge that completes its transaction.
  task automatic write_regs();
    reg_wr_t wr;
    while (reg_writes.size() != 0) begin
      wr = reg_writes.pop_front();
      cfg.valid <= 1'b1;
      cfg.index <= wr.idx;
      cfg.data  <= wr.data;
      do @(posedge clk_i); while (!cfg.ready);
      case (wr.idx)
        lgc_pkg::CFG_MODE: begin
          cur_mode = wr.data[0];
        end
        lgc_pkg::CFG_WIDTH: begin
          width_reg = wr.data;
          restart_frame();
        end
        lgc_pkg::CFG_HEIGHT: begin
          height_reg = wr.data;
          restart_frame();
        end
        default: begin
        end
      endcase
    end
    cfg.valid <= 1'b0;
  endtask

  // Twelve pixels built from boundary levels: zero, one LSB, negatives, the largest positive,
  // around full scale, and the floors of the first code, of the code where the linear toe
  // meets the power segment, and of the top code. Each channel sees them in another order.
  task automatic push_directed();
    lgc_pkg::lin_t     probe [14];
    lgc_pkg::lin_pix_t p;
    int                seam;
    seam      = (cur_mode == lgc_pkg::MODE_SRGB) ? 10 : 21;
    probe[0]  = 0;
    probe[1]  = 1;
    probe[2]  = -1;
    probe[3]  = 32'sh8000_0000;
    probe[4]  = 32'sh7FFF_FFFF;
    probe[5]  = lgc_pkg::lin_t'(FULL_SCALE - 1);
    probe[6]  = lgc_pkg::lin_t'(FULL_SCALE);
    probe[7]  = lgc_pkg::lin_t'(FULL_SCALE + 1);
    probe[8]  = lgc_pkg::lin_t'(code_floor[cur_mode][1]) - 1;
    probe[9]  = lgc_pkg::lin_t'(code_floor[cur_mode][1]);
    probe[10] = lgc_pkg::lin_t'(code_floor[cur_mode][seam]);
    probe[11] = lgc_pkg::lin_t'(code_floor[cur_mode][seam + 1]);
    probe[12] = lgc_pkg::lin_t'(code_floor[cur_mode][255]) - 1;
    probe[13] = lgc_pkg::lin_t'(code_floor[cur_mode][255]);
    for (int i = 0; i < 12; i++) begin
      p.lin_red   = probe[i];
      p.lin_green = probe[(i + 4) % 14];
      p.lin_blue  = probe[(i + 9) % 14];
      linear_q.push_back(p);
    end
  endtask

  // Pixel driver. A pixel transaction completes at an edge where valid and ready are both
  // high; the predictor takes it there, from the payload still on the channel.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (pix.valid && pix.ready) begin
        taken_pix = {pix.lin_red, pix.lin_green, pix.lin_blue};
        gamma_encode_pixel(taken_pix);
      end
      if (!pix.valid || pix.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          pix.valid <= 1'b0;
        end else if (linear_q.size() != 0) begin
          next_pix = linear_q.pop_front();
          pix.valid     <= 1'b1;
          pix.lin_red   <= next_pix.lin_red;
          pix.lin_green <= next_pix.lin_green;
          pix.lin_blue  <= next_pix.lin_blue;
          src_gap = pick_gap(src_calm);
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each result transaction is checked field by field against the oldest
  // prediction; afterwards the ready line is stalled at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (encoded_q.size() == 0) begin
          report_mismatch($sformatf("result with no pixel pending, dest_index %0d",
                                    res.dest_index));
        end else begin
          want = encoded_q.pop_front();
          if (res.code_red !== want.codes.code_red) begin
            report_mismatch($sformatf("code_red %0d, predicted %0d",
                                      res.code_red, want.codes.code_red));
          end
          if (res.code_green !== want.codes.code_green) begin
            report_mismatch($sformatf("code_green %0d, predicted %0d",
                                      res.code_green, want.codes.code_green));
          end
          if (res.code_blue !== want.codes.code_blue) begin
            report_mismatch($sformatf("code_blue %0d, predicted %0d",
                                      res.code_blue, want.codes.code_blue));
          end
          if (res.dest_index !== want.dest) begin
            report_mismatch($sformatf("dest_index %0d, predicted %0d",
                                      res.dest_index, want.dest));
          end
          if (res.frame_end !== want.last) begin
            report_mismatch($sformatf("frame_end %0b, predicted %0b",
                                      res.frame_end, want.last));
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        sink_stall = pick_gap(sink_calm);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned n;
    int          phase;
    int unsigned w;
    int unsigned h;
    int unsigned r;
    logic        m;
    bit          any_write;

    rst_ni        = 1'b0;
    pix.valid     = 1'b0;
    pix.lin_red   = '0;
    pix.lin_green = '0;
    pix.lin_blue  = '0;
    cfg.valid     = 1'b0;
    cfg.index     = lgc_pkg::CFG_MODE;
    cfg.data      = '0;
    res.ready     = 1'b0;
    mismatches    = 0;
    cycle_cnt     = 0;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;

    // The floors are fixed for the whole run, so they are worked out once, in zero time.
    build_code_floors();

    // Predictor copy of the reset state: BT.709 and a 1024 by 1024 frame.
    cur_mode   = lgc_pkg::MODE_BT709;
    width_reg  = lgc_pkg::CFG_DATA_W'(1024);
    height_reg = lgc_pkg::CFG_DATA_W'(1024);
    restart_frame();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Boundary pixels under the reset settings, then the same under sRGB.
    push_directed();
    wait_drained();
    reg_writes.push_back('{lgc_pkg::CFG_MODE, lgc_pkg::CFG_DATA_W'(lgc_pkg::MODE_SRGB)});
    write_regs();
    push_directed();
    wait_drained();

    // Random phases. The first few use fixed frame shapes: single-pixel frames, zero sizes
    // taken as one, the widest row, sizes above the maximum that saturate, and a tall frame.
    // Later phases mostly use tiny frames so that many frames wrap, and sometimes leave the
    // frame size alone so that the count runs on across a change of transfer mode.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      any_write = 1'b1;
      case (phase)
        0: begin w = 1;    h = 1;    m = lgc_pkg::MODE_BT709; end
        1: begin w = 0;    h = 0;    m = lgc_pkg::MODE_SRGB;  end
        2: begin w = 4096; h = 2;    m = lgc_pkg::MODE_BT709; end
        3: begin w = 8191; h = 8191; m = lgc_pkg::MODE_SRGB;  end
        4: begin w = 3;    h = 4096; m = lgc_pkg::MODE_BT709; end
        5: begin w = 4097; h = 1;    m = lgc_pkg::MODE_SRGB;  end
        6: begin w = 7;    h = 5;    m = lgc_pkg::MODE_BT709; end
        default: begin
          any_write = 1'b0;
          m = $urandom_range(0, 1);
          r = $urandom_range(0, 9);
          w = (r < 8) ? $urandom_range(1, 9)
                      : ((r == 8) ? $urandom_range(0, 8191) : $urandom_range(4090, 4100));
          r = $urandom_range(0, 9);
          h = (r < 8) ? $urandom_range(1, 6)
                      : ((r == 8) ? $urandom_range(0, 8191) : $urandom_range(1, 4096));
        end
      endcase
      if (any_write || $urandom_range(0, 3) != 0) begin
        reg_writes.push_back('{lgc_pkg::CFG_WIDTH, lgc_pkg::CFG_DATA_W'(w)});
      end
      if (any_write || $urandom_range(0, 3) != 0) begin
        reg_writes.push_back('{lgc_pkg::CFG_HEIGHT, lgc_pkg::CFG_DATA_W'(h)});
      end
      if (any_write || $urandom_range(0, 1) != 0 || reg_writes.size() == 0) begin
        reg_writes.push_back('{lgc_pkg::CFG_MODE, lgc_pkg::CFG_DATA_W'(m)});
      end
      write_regs();

      // Each side runs without gaps in about a quarter of the phases.
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);

      n = $urandom_range(30, 110);
      for (int i = 0; i < n; i++) begin
        // Once, halfway through a phase, the sender holds off until the encoder is empty.
        if (phase == 2 && i == n / 2) begin
          wait_drained();
        end
        next_pix.lin_red   = random_level(cur_mode);
        next_pix.lin_green = random_level(cur_mode);
        next_pix.lin_blue  = random_level(cur_mode);
        linear_q.push_back(next_pix);
      end
      sent += n;
      wait_drained();
      phase++;
    end

    // A short tail in which a stray result would still be caught.
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && encoded_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* linear_to_gamma_rgb8_encoder.f */
hdl/lgc_pkg.sv
hdl/lgc_if.sv
hdl/lgc_search.sv
hdl/lgc_index.sv
hdl/linear_to_gamma_rgb8_encoder.sv
tb/sv/linear_to_gamma_rgb8_encoder_tb.sv
